// ===== design/binary_to_decimal_ascii_top_assert.svh =====
// assertion macros for the decimal converter
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define B2DA_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, active during reset too
`define B2DA_ASSERT_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== design/b2da_pkg.sv =====
//------------------------------------------------------------------------------
// b2da_pkg
// shared constants and types of the binary to decimal ascii converter
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2da_pkg;

   localparam int VALUE_W    = 16;
   localparam int MODE_W     = 3;
   localparam int ASCII_W    = 6;
   localparam int BCD_W      = 4;
   localparam int QUEUE_DEPTH = 2;

   // v / 10 == (v * RECIP) >> RECIP_SHIFT for every 16-bit v
   localparam logic [16:0] RECIP       = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [MODE_W-1:0]  MODE_SUPPRESS = 3'd0;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== design/b2da_front.sv =====
//------------------------------------------------------------------------------
// b2da_front
// accepts a value, peels off one decimal digit per cycle, the last one once the
// queue has room, and finds the first character to print
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_front #(
   parameter int DIGITS = 5,
   parameter int IW = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   input  logic [b2da_pkg::MODE_W-1:0]  req_width_mode,
   input  b2da_pkg::q_status_type      q_status,
   output logic                        push,
   output logic [IW+DIGITS*b2da_pkg::BCD_W-1:0] push_data
);
   import b2da_pkg::*;

   logic                          active_ff, active_in;
   logic [VALUE_W-1:0]            v_ff, v_in;
   logic [MODE_W-1:0]             mode_ff, mode_in;
   logic [IW-1:0]                 k_ff, k_in;
   logic [IW-1:0]                 first_ff, first_in;
   logic [DIGITS-1:0][BCD_W-1:0]  dig_ff, dig_in;

   logic [VALUE_W+16:0]           prod;
   logic [VALUE_W-1:0]            quot;
   logic [VALUE_W-1:0]            times10;
   logic [VALUE_W-1:0]            rem_full;
   logic [BCD_W-1:0]              rem;
   logic [IW-1:0]                 first_step;
   logic [IW-1:0]                 first_out;
   logic                          last_step;
   logic                          accept;

   always_comb begin
      prod     = v_ff * RECIP;
      quot     = VALUE_W'(prod >> RECIP_SHIFT);
      times10  = (quot << 3) + (quot << 1);
      rem_full = v_ff - times10;
      rem      = rem_full[BCD_W-1:0];

      dig_in        = dig_ff;
      dig_in[k_ff]  = rem;
      // digits arrive low to high, so the last nonzero seen is the leading one
      first_step = (rem != '0) ? k_ff : first_ff;

      if (mode_ff == MODE_SUPPRESS) begin
         first_out = first_step;
      end else if (int'(mode_ff) >= DIGITS) begin
         first_out = '0;
      end else begin
         first_out = IW'(DIGITS - int'(mode_ff));
      end

      last_step = active_ff && (k_ff == '0);
      push      = last_step && !q_status.full;
      push_data = {first_out, dig_in};
      busy      = active_ff && !push;
      accept    = start && !busy;

      active_in = active_ff;
      v_in      = v_ff;
      mode_in   = mode_ff;
      k_in      = k_ff;
      first_in  = first_ff;

      if (active_ff && !last_step) begin
         v_in     = quot;
         k_in     = k_ff - 1'b1;
         first_in = first_step;
      end else if (push) begin
         active_in = 1'b0;
      end

      if (accept) begin
         active_in = 1'b1;
         v_in      = req_value;
         mode_in   = req_width_mode;
         k_in      = IW'(DIGITS - 1);
         first_in  = IW'(DIGITS - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      mode_ff  <= mode_in;
      k_ff     <= k_in;
      first_ff <= first_in;
      if (active_ff && !last_step) begin
         dig_ff <= dig_in;
      end
   end

endmodule

// ===== design/b2da_queue.sv =====
//------------------------------------------------------------------------------
// b2da_queue
// short fifo of converted numbers between front and back
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_queue #(
   parameter int DATA_W = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [DATA_W-1:0]  push_data,
   input  logic               pop,
   output logic [DATA_W-1:0]  pop_data,
   output b2da_pkg::q_status_type q_status
);
   import b2da_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      q_status.full  = (count_ff == CW'(QUEUE_DEPTH));
      q_status.empty = (count_ff == '0);
      do_push  = push && !q_status.full;
      do_pop   = pop && !q_status.empty;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/b2da_back.sv =====
//------------------------------------------------------------------------------
// b2da_back
// takes converted numbers from the queue and sends one character per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_back #(
   parameter int DIGITS = 5,
   parameter int IW = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  b2da_pkg::q_status_type      q_status,
   input  logic [IW+DIGITS*b2da_pkg::BCD_W-1:0] pop_data,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [b2da_pkg::ASCII_W-1:0] rsp_ascii_digit,
   output logic                        rsp_last_digit
);
   import b2da_pkg::*;

   logic                          active_ff, active_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [DIGITS-1:0][BCD_W-1:0]  dig_ff, dig_in;
   logic                          at_end;

   always_comb begin
      at_end = (idx_ff == IW'(DIGITS - 1));
      pop    = (!active_ff || at_end) && !q_status.empty;

      rsp_valid       = active_ff;
      rsp_ascii_digit = ASCII_ZERO + ASCII_W'(dig_ff[idx_ff]);
      rsp_last_digit  = at_end;

      active_in = active_ff;
      idx_in    = idx_ff;
      dig_in    = dig_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = pop_data[IW+DIGITS*BCD_W-1 -: IW];
         dig_in    = pop_data[DIGITS*BCD_W-1:0];
      end else if (active_ff) begin
         if (at_end) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dig_ff <= dig_in;
   end

endmodule

// ===== design/binary_to_decimal_ascii_top.sv =====
//------------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// 16-bit unsigned to ascii decimal characters, most significant first
//------------------------------------------------------------------------------
//   channel   ports                                  handshake
//   request   req_value, req_width_mode              start & !busy
//   response  rsp_ascii_digit, rsp_last_digit        rsp_valid, one cycle
//
// the front divides by ten once per cycle, holding its last digit while the
// queue is full, and takes the next number in the cycle the last is queued.
// the back sends one character per cycle, 1 to DIGITS per number; a number's
// first character follows once the front has queued it and the back popped it.
// busy is high while the front converts and while a finished number waits
// on the full two-entry queue. sync reset clears all control state.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top #(
   parameter int DIGITS = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   input  logic [b2da_pkg::MODE_W-1:0]  req_width_mode,
   output logic                         rsp_valid,
   output logic [b2da_pkg::ASCII_W-1:0] rsp_ascii_digit,
   output logic                         rsp_last_digit
);
   import b2da_pkg::*;

   localparam int IW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int DATA_W = IW + DIGITS * BCD_W;

   q_status_type      q_status;
   logic              push, pop;
   logic [DATA_W-1:0] push_data, pop_data;

   b2da_front #(.DIGITS(DIGITS), .IW(IW)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_width_mode (req_width_mode),
      .q_status       (q_status),
      .push           (push),
      .push_data      (push_data)
   );

   b2da_queue #(.DATA_W(DATA_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   b2da_back #(.DIGITS(DIGITS), .IW(IW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ascii_digit (rsp_ascii_digit),
      .rsp_last_digit  (rsp_last_digit)
   );

endmodule

// ===== design/b2da_checker.sv =====
//------------------------------------------------------------------------------
// b2da_checker
// port-level checks of the decimal converter, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_top_assert.svh"

module b2da_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [b2da_pkg::ASCII_W-1:0] rsp_ascii_digit,
   input logic                         rsp_last_digit
);
   import b2da_pkg::*;

   // every character is a decimal digit
   `B2DA_ASSERT_IMPLY(a_digit_range, clock, reset, rsp_valid, (rsp_ascii_digit >= ASCII_ZERO) && (rsp_ascii_digit <= ASCII_ZERO + 6'd9))

   // characters of one number go out without gaps
   `B2DA_ASSERT_IMPLY(a_no_gap, clock, reset, rsp_valid && !rsp_last_digit, ##1 rsp_valid)

   // reset empties the pipe
   `B2DA_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid && !busy)

   // a character never carries unknown bits
   `B2DA_ASSERT_IMPLY(a_known, clock, reset, rsp_valid, !$isunknown(rsp_ascii_digit) && !$isunknown(rsp_last_digit))

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_ascii_digit (rsp_ascii_digit),
   .rsp_last_digit  (rsp_last_digit)
);

// ===== tb/sv/binary_to_decimal_ascii_checker.sv =====
//------------------------------------------------------------------------------
// binary_to_decimal_ascii_checker
// watches both channels of the decimal converter and checks every character
//------------------------------------------------------------------------------
// every number taken on the request channel is expanded into the characters
// it must produce. each character on the response channel is compared with
// the oldest of those, field by field. the top reads the failure count, the
// number of characters still owed and a few totals for its summary.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii_checker #(
   parameter int DIGITS = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [b2da_pkg::VALUE_W-1:0] req_value,
   input  logic [b2da_pkg::MODE_W-1:0]  req_width_mode,
   input  logic                         rsp_valid,
   input  logic [b2da_pkg::ASCII_W-1:0] rsp_ascii_digit,
   input  logic                         rsp_last_digit,
   output int                           fail_count,
   output int                           chars_owed,
   output int                           numbers_taken,
   output int                           chars_checked
);
   import b2da_pkg::*;

   typedef struct packed {
      logic [ASCII_W-1:0] code;
      logic               last;
   } decimal_char_type;

   decimal_char_type owed_chars[$];

   // expand one number into its characters, most significant first
   function automatic void queue_decimal_chars(input logic [VALUE_W-1:0] number,
                                               input logic [MODE_W-1:0]  mode);
      logic [BCD_W-1:0] dig[DIGITS];
      int               rest;
      int               first;
      int               shown;
      decimal_char_type ch;
      rest = number;
      for (int k = DIGITS - 1; k >= 0; k--) begin
         dig[k] = BCD_W'(rest % 10);
         rest   = rest / 10;
      end
      if (mode == MODE_SUPPRESS) begin
         // keep at least the units digit so zero still prints
         first = 0;
         while (first < DIGITS - 1 && dig[first] == 0)
            first++;
      end else begin
         shown = (int'(mode) > DIGITS) ? DIGITS : int'(mode);
         first = DIGITS - shown;
      end
      for (int k = first; k < DIGITS; k++) begin
         ch.code = ASCII_ZERO + ASCII_W'(dig[k]);
         ch.last = (k == DIGITS - 1);
         owed_chars.push_back(ch);
      end
   endfunction

   initial begin
      fail_count    = 0;
      chars_owed    = 0;
      numbers_taken = 0;
      chars_checked = 0;
   end

   always @(posedge clock) begin
      decimal_char_type want;
      if (!reset) begin
         // compare before queuing: a character never belongs to this edge's transaction
         if (rsp_valid) begin
            if (owed_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                        $time, rsp_ascii_digit, rsp_last_digit);
               fail_count++;
            end else begin
               want = owed_chars.pop_front();
               chars_checked++;
               if (rsp_ascii_digit !== want.code) begin
                  $display("%0t: ascii_digit mismatch: expected %0d, actual %0d",
                           $time, want.code, rsp_ascii_digit);
                  fail_count++;
               end
               if (rsp_last_digit !== want.last) begin
                  $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last_digit);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            queue_decimal_chars(req_value, req_width_mode);
            numbers_taken++;
         end
      end
      chars_owed = owed_chars.size();
   end

endmodule

// ===== tb/sv/binary_to_decimal_ascii_top_test.sv =====
//------------------------------------------------------------------------------
// binary_to_decimal_ascii_top_test
// stimulus and verdict for the binary to decimal ascii converter
//------------------------------------------------------------------------------
// a directed set covers zero, the largest value, every width mode including
// the saturating ones and the leading zero cases. random numbers of mixed
// magnitude follow in phases with and without gaps on the request side.
// the checker module does all prediction and comparison.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_test;
   import b2da_pkg::*;

   localparam int DIGITS       = 5;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 4 * DIGITS + 20;
   localparam int PHASE_ITEMS  = 50;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [VALUE_W-1:0] req_value;
   logic [MODE_W-1:0]  req_width_mode;
   logic               rsp_valid;
   logic [ASCII_W-1:0] rsp_ascii_digit;
   logic               rsp_last_digit;

   int fail_count;
   int chars_owed;
   int numbers_taken;
   int chars_checked;
   int cycle_count;

   // request side idle percentage per phase; the receiver cannot stall
   int idle_pct[4] = '{0, 46, 0, 38};

   binary_to_decimal_ascii_top #(.DIGITS(DIGITS)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_width_mode (req_width_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_digit(rsp_ascii_digit),
      .rsp_last_digit (rsp_last_digit)
   );

   binary_to_decimal_ascii_checker #(.DIGITS(DIGITS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .req_width_mode (req_width_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_digit(rsp_ascii_digit),
      .rsp_last_digit (rsp_last_digit),
      .fail_count     (fail_count),
      .chars_owed     (chars_owed),
      .numbers_taken  (numbers_taken),
      .chars_checked  (chars_checked)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still owed",
                  cycle_count, chars_owed);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // start stays high from one transaction to the next unless a gap is rolled
   task automatic send_number(input logic [VALUE_W-1:0] number,
                              input logic [MODE_W-1:0]  mode,
                              input int                 gap_pct);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start = 1'b0;
         req_value      = VALUE_W'($urandom);
         req_width_mode = MODE_W'($urandom);
         @(negedge clock);
      end
      start          = 1'b1;
      req_value      = number;
      req_width_mode = mode;
      do
         @(posedge clock);
      while (busy);
   endtask

   // mostly short numbers so leading zeros are common
   function automatic logic [VALUE_W-1:0] random_number();
      int span;
      case ($urandom_range(5))
         0: span = 9;
         1: span = 99;
         2: span = 999;
         3: span = 9999;
         default: span = 65535;
      endcase
      return VALUE_W'($urandom_range(span));
   endfunction

   initial begin
      start          = 1'b0;
      reset          = 1'b1;
      req_value      = '0;
      req_width_mode = MODE_SUPPRESS;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int m = 0; m < 8; m++) send_number(16'd0, MODE_W'(m), 0);
      for (int m = 0; m < 8; m++) send_number(16'hFFFF, MODE_W'(m), 0);
      send_number(16'd1,     MODE_SUPPRESS, 0);
      send_number(16'd9,     MODE_SUPPRESS, 0);
      send_number(16'd10,    MODE_SUPPRESS, 0);
      send_number(16'd99,    MODE_SUPPRESS, 0);
      send_number(16'd100,   MODE_SUPPRESS, 0);
      send_number(16'd10000, MODE_SUPPRESS, 0);
      send_number(16'd12345, MODE_SUPPRESS, 0);
      send_number(16'd40960, MODE_SUPPRESS, 0);

      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_number(random_number(), MODE_W'($urandom_range(7)), idle_pct[p]);
      end
      @(negedge clock);
      start = 1'b0;

      while (chars_owed != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d numbers, checked %0d characters", numbers_taken,
               chars_checked);
      $display("all width modes, zero and full scale values, gaps on the request side");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
